// ----- sv/vtag_pkg.sv -----
// Shared types and constants for the source-address VLAN tag inserter.
// No dependencies; imported by every module of the block.
`default_nettype none

package vtag_pkg;

   localparam int REQ_DATA_W = 64;
   localparam int BYTE_W     = 8;
   localparam int ENTRY_IX_W = 4;
   localparam int IP_W       = 32;
   localparam int VLAN_W     = 12;

   // Header window: bytes 12..29 are held, the decision falls on byte 29
   localparam int HOLD_FIRST = 12;
   localparam int HOLD_LEN   = 18;
   localparam int DECIDE_POS = 29;
   localparam int HIX_W      = 5;

   localparam logic [HIX_W-1:0] TAG_LAST_IX  = HIX_W'(3);
   localparam logic [HIX_W-1:0] HOLD_LAST_IX = HIX_W'(HOLD_LEN - 1);

   localparam logic [BYTE_W-1:0] TPID_HI = 8'h81;
   localparam logic [BYTE_W-1:0] TPID_LO = 8'h00;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_TABLE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_TAG,
      ST_HOLD
   } vtag_state_type;

   typedef struct packed {
      logic                  en;
      logic [ENTRY_IX_W-1:0] index;
      logic [IP_W-1:0]       ip;
      logic [VLAN_W-1:0]     vlan;
      logic                  valid;
   } vtag_table_write_type;

   typedef struct packed {
      logic              done;
      logic              hit;
      logic [VLAN_W-1:0] vlan;
   } vtag_lookup_result_type;

endpackage

`default_nettype wire

// ----- sv/vlan_tag_inserter_by_source_ip_unit.sv -----
// Top level of the source-address VLAN tag inserter: frame sequencer, header hold
// buffer and output register. Depends on vtag_pkg and vtag_lookup.
`default_nettype none

// Frames enter one byte per transfer; table writes (tuser high) load one slot and
// produce nothing. Bytes 0 to 11 and everything after byte 29 go out one per cycle
// while the output is not stalled. Bytes 12 to 29 are held; on byte 29 the source
// address is searched in the table, one entry per cycle, during which no transfer is
// accepted. The burst that follows (4 tag bytes on a hit, then the 18 held bytes)
// leaves at one byte per cycle, unless the output stalls, while the input is held off.
// A frame ending inside the hold window is flushed unchanged the same way. The output
// register lets a new input be taken in the cycle that its waiting byte is taken.
module vlan_tag_inserter_by_source_ip_unit #(
   parameter int TABLE_DEPTH     = 16,
   parameter int MAX_FRAME_BYTES = 1522
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // data_byte[7:0], entry_index[11:8], entry_ip[43:12], entry_vlan[55:44],
   // entry_valid[56], zero fill up to bit 63
   input  wire [vtag_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire                                req_tlast,
   // opcode[0]
   input  wire                                req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // out_byte[7:0]
   output logic [vtag_pkg::BYTE_W-1:0]        rsp_tdata,
   output logic                               rsp_tlast,
   // tagged_res[0]
   output logic                               rsp_tuser
);
   import vtag_pkg::*;

   localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [PW-1:0] POS_HOLD   = PW'(HOLD_FIRST);
   localparam logic [PW-1:0] POS_DECIDE = PW'(DECIDE_POS);
   localparam logic [PW-1:0] POS_AFTER  = PW'(DECIDE_POS + 1);
   localparam logic [PW-1:0] POS_MAX    = PW'(MAX_FRAME_BYTES);

   vtag_state_type state_ff, state_in;

   logic [PW-1:0]     pos_ff;
   logic              frame_tagged_ff;
   logic [BYTE_W-1:0] hold_ff [HOLD_LEN];
   logic [23:0]       ip_ff;
   logic [HIX_W-1:0]  k_ff;
   logic [HIX_W-1:0]  end_ff;
   logic              last_ff;
   logic [VLAN_W-1:0] vlan_ff;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;
   logic              rsp_tag_ff;

   vtag_table_write_type   wr;
   vtag_lookup_result_type lk;

   logic              out_free;
   logic              acc;
   logic              frame_acc;
   logic [BYTE_W-1:0] in_byte;
   logic              pos_pass;
   logic              pos_hold;
   logic              pos_decide;
   logic [HIX_W-1:0]  hold_ix;
   logic              lk_start;
   logic              emit;
   logic [BYTE_W-1:0] emit_byte;
   logic              emit_last;
   logic              emit_tag;

   assign in_byte    = req_tdata[BYTE_W-1:0];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pos_pass   = (pos_ff < POS_HOLD) || (pos_ff > POS_DECIDE);
   assign pos_hold   = (pos_ff >= POS_HOLD) && (pos_ff < POS_DECIDE);
   assign pos_decide = (pos_ff == POS_DECIDE);
   assign hold_ix    = HIX_W'(pos_ff - POS_HOLD);

   vtag_lookup #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_lookup (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .start (lk_start),
      .ip    ({ip_ff, in_byte}),
      .result(lk)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (frame_acc && pos_hold && req_tlast) begin
               state_in = ST_HOLD;
            end else if (frame_acc && pos_decide) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (lk.done) begin
               state_in = lk.hit ? ST_TAG : ST_HOLD;
            end
         end
         ST_TAG: begin
            if (out_free && (k_ff == TAG_LAST_IX)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free && (k_ff == end_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE) && out_free;
      acc        = req_tvalid && req_tready;
      frame_acc  = acc && (req_tuser == OP_FRAME);
      wr.en      = acc && (req_tuser == OP_TABLE);
      wr.index   = req_tdata[11:8];
      wr.ip      = req_tdata[43:12];
      wr.vlan    = req_tdata[55:44];
      wr.valid   = req_tdata[56];
      lk_start   = frame_acc && pos_decide;
      emit       = 1'b0;
      emit_byte  = in_byte;
      emit_last  = req_tlast;
      emit_tag   = frame_tagged_ff;
      case (state_ff)
         ST_IDLE: begin
            emit = frame_acc && pos_pass;
         end
         ST_TAG: begin
            emit      = out_free;
            emit_last = 1'b0;
            emit_tag  = 1'b1;
            case (k_ff[1:0])
               2'd0:    emit_byte = TPID_HI;
               2'd1:    emit_byte = TPID_LO;
               2'd2:    emit_byte = {4'b0000, vlan_ff[11:8]};
               default: emit_byte = vlan_ff[7:0];
            endcase
         end
         ST_HOLD: begin
            emit      = out_free;
            emit_byte = hold_ff[k_ff];
            emit_last = last_ff && (k_ff == end_ff);
         end
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pos_ff          <= '0;
         frame_tagged_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
         case (state_ff)
            ST_IDLE: begin
               if (frame_acc) begin
                  if (req_tlast && !pos_decide) begin
                     pos_ff          <= '0;
                     frame_tagged_ff <= 1'b0;
                  end else if (!pos_decide && (pos_ff < POS_MAX)) begin
                     pos_ff <= pos_ff + PW'(1);
                  end
               end
            end
            ST_LOOKUP: begin
               if (lk.done) begin
                  frame_tagged_ff <= lk.hit;
               end
            end
            ST_HOLD: begin
               if (out_free && (k_ff == end_ff)) begin
                  if (last_ff) begin
                     pos_ff          <= '0;
                     frame_tagged_ff <= 1'b0;
                  end else begin
                     pos_ff <= POS_AFTER;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last;
         rsp_tag_ff  <= emit_tag;
      end
      if (frame_acc && (pos_hold || pos_decide)) begin
         hold_ff[hold_ix] <= in_byte;
         ip_ff            <= {ip_ff[15:0], in_byte};
      end
      case (state_ff)
         ST_IDLE: begin
            k_ff <= '0;
            if (pos_decide) begin
               end_ff  <= HOLD_LAST_IX;
               last_ff <= req_tlast;
            end else begin
               // flush of a short frame ends on the byte just taken
               end_ff  <= hold_ix;
               last_ff <= 1'b1;
            end
         end
         ST_LOOKUP: begin
            k_ff <= '0;
            if (lk.done) begin
               vlan_ff <= lk.vlan;
            end
         end
         ST_TAG: begin
            if (out_free) begin
               k_ff <= (k_ff == TAG_LAST_IX) ? '0 : k_ff + HIX_W'(1);
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               k_ff <= k_ff + HIX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_tag_ff;

endmodule

`default_nettype wire

// ----- sv/vtag_lookup.sv -----
// Address-to-VLAN table with a sequential search that compares one entry per cycle.
// Depends on vtag_pkg.
`default_nettype none

module vtag_lookup #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  vtag_pkg::vtag_table_write_type   wr,
   input  wire                              start,
   input  wire [vtag_pkg::IP_W-1:0]         ip,
   output vtag_pkg::vtag_lookup_result_type result
);
   import vtag_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_DEPTH);

   logic [IP_W-1:0]        mem_addr [TABLE_DEPTH];
   logic [VLAN_W-1:0]      mem_vlan [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   logic            busy_ff;
   logic            pend_ff;
   logic [CW-1:0]   cnt_ff;
   logic [IP_W-1:0] ip_ff;
   logic [IP_W-1:0] rd_addr_ff;
   logic [VLAN_W-1:0] rd_vlan_ff;
   logic            rd_valid_ff;

   logic          wr_ok;
   logic [IW-1:0] wr_ix;
   logic [IW-1:0] rd_ix;
   logic          issue;
   logic          hit_now;
   logic          miss_now;

   assign wr_ok    = wr.en && (32'(wr.index) < 32'(TABLE_DEPTH));
   assign wr_ix    = IW'(wr.index);
   assign rd_ix    = cnt_ff[IW-1:0];
   assign issue    = busy_ff && (cnt_ff < LAST_CNT);
   assign hit_now  = busy_ff && pend_ff && rd_valid_ff && (rd_addr_ff == ip_ff);
   assign miss_now = busy_ff && !pend_ff && (cnt_ff == LAST_CNT);

   assign result.done = hit_now || miss_now;
   assign result.hit  = hit_now;
   assign result.vlan = rd_vlan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         cnt_ff   <= '0;
         valid_ff <= '0;
      end else begin
         if (wr_ok) begin
            valid_ff[wr_ix] <= wr.valid;
         end
         if (start) begin
            busy_ff <= 1'b1;
            pend_ff <= 1'b0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (hit_now || miss_now) begin
               busy_ff <= 1'b0;
               pend_ff <= 1'b0;
            end else begin
               pend_ff <= issue;
               if (issue) begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_addr[wr_ix] <= wr.ip;
         mem_vlan[wr_ix] <= wr.vlan;
      end
      if (start) begin
         ip_ff <= ip;
      end
      if (issue) begin
         rd_addr_ff  <= mem_addr[rd_ix];
         rd_vlan_ff  <= mem_vlan[rd_ix];
         rd_valid_ff <= valid_ff[rd_ix];
      end
   end

endmodule

`default_nettype wire

// ----- sv/vtag_checker.sv -----
// Port-level checks for the source-address VLAN tag inserter, bound to its top level.
// Depends on vtag_pkg and vlan_tag_inserter_by_source_ip_unit.
`default_nettype none

module vtag_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tvalid,
   input wire                            req_tready,
   input wire                            req_tuser,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [vtag_pkg::BYTE_W-1:0]     rsp_tdata,
   input wire                            rsp_tlast,
   input wire                            rsp_tuser
);
   import vtag_pkg::*;

   logic in_tagged_ff;
   logic rsp_xfer;

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // track whether the frame on the output has started carrying tagged bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         in_tagged_ff <= 1'b0;
      end else if (rsp_xfer) begin
         in_tagged_ff <= rsp_tuser && !rsp_tlast;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_ready_slot: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("input taken with no room in the output register");

   a_table_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_TABLE) |=> !rsp_tvalid)
      else $error("table write produced an output transfer");

   a_tag_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && in_tagged_ff |-> rsp_tuser)
      else $error("tag flag dropped inside a tagged frame");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule

bind vlan_tag_inserter_by_source_ip_unit vtag_checker u_vtag_checker (.*);

`default_nettype wire

// ----- verif/vtag_stream_checker.sv -----
// Output checker for the source-address VLAN tag inserter: predicts every output byte
// from the accepted input transfers and compares it against the result stream.
// Depends on vtag_pkg.
module vtag_stream_checker #(
   parameter int TABLE_DEPTH     = 16,
   parameter int MAX_FRAME_BYTES = 1522
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [vtag_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [vtag_pkg::BYTE_W-1:0]     rsp_tdata,
   input  logic                            rsp_tlast,
   input  logic                            rsp_tuser,
   output int                              mismatches,
   output int                              pending,
   output int                              frames_done,
   output int                              frames_tagged,
   output int                              frames_short,
   output int                              slot_writes,
   output int                              bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import vtag_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              tag;
   } egress_byte_type;

   egress_byte_type   egress_due[$];

   // Predicted block state
   logic [10:0]       position;
   logic              frame_tagged;
   logic [BYTE_W-1:0] held_header [HOLD_LEN];
   logic [IP_W-1:0]   slot_ip     [TABLE_DEPTH];
   logic [VLAN_W-1:0] slot_vid    [TABLE_DEPTH];
   logic              slot_on     [TABLE_DEPTH];

   initial begin
      mismatches    = 0;
      pending       = 0;
      frames_done   = 0;
      frames_tagged = 0;
      frames_short  = 0;
      slot_writes   = 0;
      bytes_checked = 0;
   end

   task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic last,
                             input logic tag);
      egress_byte_type e;
      e.data = data;
      e.last = last;
      e.tag  = tag;
      egress_due.push_back(e);
   endtask

   task automatic predict_transfer(input logic op, input logic [REQ_DATA_W-1:0] d,
                                   input logic last);
      logic [BYTE_W-1:0]     b;
      logic [ENTRY_IX_W-1:0] ix;
      logic [IP_W-1:0]       src;
      logic [VLAN_W-1:0]     vid;
      logic                  hit;
      int                    fill;
      b  = d[7:0];
      ix = d[11:8];
      if (op == OP_TABLE) begin
         if (ix < TABLE_DEPTH) begin
            slot_ip[ix]  = d[43:12];
            slot_vid[ix] = d[55:44];
            slot_on[ix]  = d[56];
         end
         slot_writes++;
         return;
      end

      if (position < HOLD_FIRST) begin
         queue_byte(b, last, 1'b0);
      end else if (position < DECIDE_POS) begin
         held_header[position - HOLD_FIRST] = b;
         if (last) begin
            // frame ended inside the header window: flush what was held
            fill = position - HOLD_FIRST + 1;
            for (int i = 0; i < fill; i++)
               queue_byte(held_header[i], i == fill - 1, 1'b0);
         end
      end else if (position == DECIDE_POS) begin
         held_header[HOLD_LEN-1] = b;
         src = {held_header[14], held_header[15], held_header[16], held_header[17]};
         hit = 1'b0;
         vid = '0;
         // lowest matching slot wins
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!hit && slot_on[i] && slot_ip[i] == src) begin
               hit = 1'b1;
               vid = slot_vid[i];
            end
         end
         if (hit) begin
            queue_byte(TPID_HI, 1'b0, 1'b1);
            queue_byte(TPID_LO, 1'b0, 1'b1);
            queue_byte({4'h0, vid[11:8]}, 1'b0, 1'b1);
            queue_byte(vid[7:0], 1'b0, 1'b1);
            frames_tagged++;
         end
         for (int i = 0; i < HOLD_LEN; i++)
            queue_byte(held_header[i], last && i == HOLD_LEN - 1, hit);
         frame_tagged = hit;
      end else begin
         queue_byte(b, last, frame_tagged);
      end

      if (last) begin
         if (position < DECIDE_POS)
            frames_short++;
         frames_done++;
         position     = '0;
         frame_tagged = 1'b0;
      end else if (position < MAX_FRAME_BYTES) begin
         position = position + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      egress_byte_type want;
      if (reset) begin
         position     = '0;
         frame_tagged = 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++)
            slot_on[i] = 1'b0;
         egress_due.delete();
      end else begin
         if (req_tvalid && req_tready)
            predict_transfer(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (egress_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected output byte, expected none, actual %h last %b tag %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = egress_due.pop_front();
               if (rsp_tdata !== want.data) begin
                  mismatches++;
                  $display("%0t: byte %0d data, expected %h actual %h",
                           $time, bytes_checked, want.data, rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  mismatches++;
                  $display("%0t: byte %0d last flag, expected %b actual %b",
                           $time, bytes_checked, want.last, rsp_tlast);
               end
               if (rsp_tuser !== want.tag) begin
                  mismatches++;
                  $display("%0t: byte %0d tag flag, expected %b actual %b",
                           $time, bytes_checked, want.tag, rsp_tuser);
               end
            end
            bytes_checked++;
         end
      end
      pending = egress_due.size();
   end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the source-address VLAN tag inserter: clock, reset, frame and
// table-write stimulus, output back-pressure and verdict. Depends on vtag_pkg,
// vtag_stream_checker and the block itself.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vtag_pkg::*;

   localparam int RANDOM_ITEMS   = 40;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SINK_HOLD      = 300;
   localparam int MAX_FRAME      = 64;
   localparam int OVERSIZE_LEN   = 72;
   localparam int DRAIN_TAIL     = 60;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    req_tuser  = OP_FRAME;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [BYTE_W-1:0]       rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;

   int  mismatches, pending, frames_done, frames_tagged, frames_short;
   int  slot_writes, bytes_checked;
   int  transfers_offered = 0;
   bit  idle_on = 1'b0;
   bit  sink_hold_req = 1'b0;
   logic [IP_W-1:0] ip_pool [8];

   always #4 clock = ~clock;

   vlan_tag_inserter_by_source_ip_unit #(
      .MAX_FRAME_BYTES(MAX_FRAME)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   vtag_stream_checker #(
      .MAX_FRAME_BYTES(MAX_FRAME)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .mismatches    (mismatches),
      .pending       (pending),
      .frames_done   (frames_done),
      .frames_tagged (frames_tagged),
      .frames_short  (frames_short),
      .slot_writes   (slot_writes),
      .bytes_checked (bytes_checked)
   );

   // Random content for the fields a transfer does not use; zero fill above bit 56
   function automatic logic [REQ_DATA_W-1:0] noise();
      return {$urandom, $urandom} & 64'h01FF_FFFF_FFFF_FFFF;
   endfunction

   function automatic logic [IP_W-1:0] pick_source();
      if ($urandom_range(0, 3) != 0)
         return ip_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic offer(input logic op, input logic [REQ_DATA_W-1:0] d, input logic last);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      transfers_offered++;
   endtask

   task automatic write_slot(input logic [ENTRY_IX_W-1:0] ix, input logic [IP_W-1:0] ip,
                             input logic [VLAN_W-1:0] vid, input logic on);
      logic [REQ_DATA_W-1:0] d;
      d        = noise();
      d[11:8]  = ix;
      d[43:12] = ip;
      d[55:44] = vid;
      d[56]    = on;
      offer(OP_TABLE, d, 1'($urandom_range(0, 1)));
   endtask

   task automatic write_random_slot();
      write_slot(ENTRY_IX_W'($urandom_range(0, 15)),
                 ($urandom_range(0, 4) != 0) ? ip_pool[$urandom_range(0, 7)] : $urandom,
                 VLAN_W'($urandom_range(0, 4095)), $urandom_range(0, 4) != 0);
   endtask

   // Source address lands in bytes 26..29, most significant byte first
   task automatic send_frame(input int len, input logic [IP_W-1:0] src, input int write_pct);
      logic [REQ_DATA_W-1:0] d;
      for (int i = 0; i < len; i++) begin
         if (write_pct > 0 && $urandom_range(0, 99) < write_pct)
            write_random_slot();
         d = noise();
         if (i >= 26 && i <= 29)
            d[7:0] = src[8*(29-i) +: 8];
         offer(OP_FRAME, d, i == len - 1);
      end
   endtask

   // Hold the input until every predicted byte has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : sink
      @(posedge clock);
      forever begin
         if (sink_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (SINK_HOLD) @(posedge clock);
            sink_hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int start;
      int pick;
      int len;
      ip_pool[0] = 32'h0000_0000;
      ip_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++)
         ip_pool[i] = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      // Directed: field extremes, priority, short frames, end on the decision byte
      write_slot('0, ip_pool[0], '0, 1'b1);
      write_slot(4'hF, ip_pool[1], 12'hFFF, 1'b1);
      write_slot(4'd3, ip_pool[2], 12'h5A5, 1'b1);
      write_slot(4'd7, ip_pool[2], 12'hA5A, 1'b1);
      send_frame(30, ip_pool[1], 0);
      send_frame(1, ip_pool[0], 0);
      send_frame(12, ip_pool[0], 0);
      send_frame(13, ip_pool[0], 0);
      send_frame(29, ip_pool[0], 0);
      send_frame(34, ip_pool[0], 0);
      send_frame(34, ip_pool[2], 0);
      write_slot(4'd3, ip_pool[2], 12'h5A5, 1'b0);
      send_frame(34, ip_pool[2], 0);
      send_frame(34, ip_pool[3], 0);
      drain();

      // Random frames with table writes in between and inside frames
      start = transfers_offered;
      while (transfers_offered - start < RANDOM_ITEMS) begin
         idle_on = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) write_random_slot();
         pick = $urandom_range(0, 99);
         if (pick < 20)
            len = $urandom_range(1, 29);
         else if (pick < 30)
            len = 30;
         else if (pick < 90)
            len = $urandom_range(31, 40);
         else
            len = $urandom_range(41, 120);
         send_frame(len, pick_source(), 4);
      end

      // Long output stall while the input keeps offering
      drain();
      idle_on = 1'b0;
      sink_hold_req = 1'b1;
      send_frame(40, ip_pool[0], 0);
      send_frame(31, pick_source(), 0);
      drain();

      // Final stretch without idling, including a frame past the maximum length
      send_frame(OVERSIZE_LEN, ip_pool[1], 0);
      repeat (2) send_frame($urandom_range(1, 40), pick_source(), 4);
      drain();
      repeat (DRAIN_TAIL) @(posedge clock);

      $display("Covered %0d input transfers: %0d table writes, %0d frames",
               transfers_offered, slot_writes, frames_done);
      $display("  %0d tagged, %0d short, %0d output bytes checked, stalls and oversize",
               frames_tagged, frames_short, bytes_checked);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
sv/vtag_pkg.sv
sv/vtag_lookup.sv
sv/vlan_tag_inserter_by_source_ip_unit.sv
sv/vtag_checker.sv
verif/vtag_stream_checker.sv
verif/tb_top.sv
